/* hw/rtl/hdlcd_pkg.sv */
// Shared types and constants for the HDLC receive bit destuffer.
// Used by the front, queue, back and top level modules; no dependencies.
package hdlcd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FLAG  = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;

  localparam logic [7:0] FLAG_PATTERN = 8'h7E;
  localparam logic [3:0] RUN_MAX      = 4'd8;
  localparam logic [3:0] RUN_STUFF    = 4'd5;
  localparam logic [3:0] RUN_FLAG     = 4'd6;
  localparam logic [3:0] COUNT_MAX    = 4'd15;
  localparam logic [3:0] OCTET_BITS   = 4'd8;

  // One result event
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } hdlcd_ev_t;

  // Queue entry: results caused by one input octet (one or two)
  typedef struct packed {
    logic      two;
    hdlcd_ev_t ev0;
    hdlcd_ev_t ev1;
  } hdlcd_entry_t;

endpackage

/* hw/rtl/hdlcd_front.sv */
// Front end: accepts raw octets, runs the eight-bit destuff/flag/abort logic
// and pushes the resulting events into the queue. Depends on hdlcd_pkg.
module hdlcd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_raw_bits,
  output logic                  push,
  output hdlcd_pkg::hdlcd_entry_t push_entry,
  input  logic                  q_full
);
  import hdlcd_pkg::*;

  logic [3:0] ones_run_r, ones_run_nxt;
  logic [7:0] asm_r, asm_nxt;
  logic [3:0] bits_r, bits_nxt;
  logic [1:0] n_ev;
  hdlcd_ev_t  ev [2];
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Unrolled bit walk, MSB first
  always_comb begin
    logic [3:0] run;
    logic [7:0] asm_v;
    logic [3:0] cnt;
    logic [1:0] n;
    logic       b;
    run   = ones_run_r;
    asm_v = asm_r;
    cnt   = bits_r;
    n     = 2'd0;
    ev[0] = '{kind: KIND_DATA, data_byte: 8'h00};
    ev[1] = '{kind: KIND_DATA, data_byte: 8'h00};
    for (int i = 7; i >= 0; i--) begin
      b = in_raw_bits[3'(i)];
      if (b) begin
        if (run < RUN_MAX) run = run + 4'd1;
        asm_v = {asm_v[6:0], 1'b1};
        if (cnt < COUNT_MAX) cnt = cnt + 4'd1;
      end else begin
        if (run < RUN_STUFF) begin
          asm_v = {asm_v[6:0], 1'b0};
          if (cnt < COUNT_MAX) cnt = cnt + 4'd1;
        end else if (run == RUN_FLAG) begin
          asm_v = {asm_v[6:0], 1'b0};
          if (asm_v == FLAG_PATTERN && n < 2'd2) begin
            ev[n[0]] = '{kind: KIND_FLAG, data_byte: 8'h00};
            n = n + 2'd1;
          end
          asm_v = 8'h00;
          cnt   = 4'd0;
        end else if (run >= RUN_MAX) begin
          if (n < 2'd2) begin
            ev[n[0]] = '{kind: KIND_ABORT, data_byte: 8'h00};
            n = n + 2'd1;
          end
          asm_v = 8'h00;
          cnt   = 4'd0;
        end
        run = 4'd0;
      end
      // full octet assembled outside an abort run
      if (cnt == OCTET_BITS && run < RUN_MAX) begin
        if (n < 2'd2) begin
          ev[n[0]] = '{kind: KIND_DATA, data_byte: asm_v};
          n = n + 2'd1;
        end
        asm_v = 8'h00;
        cnt   = 4'd0;
      end
    end
    ones_run_nxt = run;
    asm_nxt      = asm_v;
    bits_nxt     = cnt;
    n_ev         = n;
  end

  assign push           = accept && (n_ev != 2'd0);
  assign push_entry.two = n_ev[1];
  assign push_entry.ev0 = ev[0];
  assign push_entry.ev1 = ev[1];

  // Line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ones_run_r <= 4'd0;
      asm_r      <= 8'h00;
      bits_r     <= 4'd0;
    end else if (accept) begin
      ones_run_r <= ones_run_nxt;
      asm_r      <= asm_nxt;
      bits_r     <= bits_nxt;
    end
  end

  a_run_sat: assert property (@(posedge clk) disable iff (!rst_n)
    ones_run_r <= RUN_MAX)
    else $error("ones run above saturation");

  // a full octet can only sit in the register during an abort run
  a_octet_held: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r >= OCTET_BITS |-> ones_run_r == RUN_MAX)
    else $error("assembled octet not emitted");

endmodule

/* hw/rtl/hdlcd_queue.sv */
// Short queue of event entries between front and back ends.
// Depends on hdlcd_pkg for the entry type.
module hdlcd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  hdlcd_pkg::hdlcd_entry_t push_entry,
  output logic                    full,
  input  logic                    pop,
  output logic                    empty,
  output hdlcd_pkg::hdlcd_entry_t head
);
  import hdlcd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hdlcd_entry_t  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Pointer wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push)
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (do_pop)
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    if (do_push && !do_pop)      count_nxt = count_r + CW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count overflow");

endmodule

/* hw/rtl/hdlcd_back.sv */
// Back end: serializes queue entries into one result per transaction,
// marking the final result of each input. Depends on hdlcd_pkg.
module hdlcd_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  hdlcd_pkg::hdlcd_entry_t head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_kind,
  output logic [7:0]              out_data_byte,
  output logic                    out_last
);
  import hdlcd_pkg::*;

  logic      sel_r, sel_nxt;
  hdlcd_ev_t cur;
  logic      fire;

  assign out_valid     = !q_empty;
  assign cur           = sel_r ? head.ev1 : head.ev0;
  assign out_kind      = cur.kind;
  assign out_data_byte = cur.data_byte;
  assign out_last      = sel_r || !head.two;
  assign fire          = out_valid && out_ready;
  assign pop           = fire && out_last;

  // Second-result select
  always_comb begin
    sel_nxt = sel_r;
    if (fire) sel_nxt = !out_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sel_r <= 1'b0;
    else        sel_r <= sel_nxt;
  end

  a_sel_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> out_valid && head.two)
    else $error("second result selected without a two-result entry");

  a_last_resets_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !sel_r)
    else $error("select not cleared after final result");

endmodule

/* hw/rtl/hdlc_bit_destuffer_rx_top.sv */
// Top level of the HDLC receive bit destuffer with flag and abort detection.
// Depends on hdlcd_pkg, hdlcd_front, hdlcd_queue and hdlcd_back.
//
//  Channel | Ports                                    | Direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_ready, in_raw_bits          | in
//  result  | out_valid, out_ready, out_kind,          | out
//          | out_data_byte, out_last                  |
//
// One raw octet is accepted per cycle while the queue has room; its bits are
// walked combinationally by the front end. Each input yields zero, one or two
// results, sent one per cycle by the back end while out_ready is high, so
// sustained rate is one octet per cycle with at most one result per octet.
// Reset (rst_n low, synchronous) clears line state, queue and select.
// A stalled result channel fills the queue (QUEUE_DEPTH entries), then
// in_ready drops.
module hdlc_bit_destuffer_rx_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_raw_bits,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic       out_last
);
  import hdlcd_pkg::*;

  logic         push, pop, q_full, q_empty;
  hdlcd_entry_t push_entry, head;

  hdlcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_raw_bits(in_raw_bits),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  hdlcd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  hdlcd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_data_byte(out_data_byte),
    .out_last     (out_last)
  );

endmodule

/* sim/hdlc_bit_destuffer_rx_top_tb.sv */
// Self-checking testbench for hdlc_bit_destuffer_rx_top: line octets in, destuffed events out.
// Depends on hdlcd_pkg and the RTL under hw/rtl; a scoreboard class predicts every event.
module hdlc_bit_destuffer_rx_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hdlcd_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_OCTETS = 1930;
  localparam int MAX_WAIT     = 13;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 1000000;

  // One expected or observed event on the result channel
  typedef struct {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;
  } dest_result_t;

  // Receive-side line model plus the queue of events still to come out
  class destuff_scoreboard;
    logic [3:0]   run_len;
    logic [7:0]   shreg;
    logic [3:0]   nbits;
    dest_result_t batch[$];
    dest_result_t expected_results[$];
    int           errors;

    function new();
      run_len = '0;
      shreg   = '0;
      nbits   = '0;
      errors  = 0;
    endfunction

    function void push_bit(logic b);
      shreg = {shreg[6:0], b};
      if (nbits < COUNT_MAX) nbits++;
    endfunction

    // At most two events per octet; anything beyond is dropped
    function void add_event(logic [1:0] kind, logic [7:0] data_byte);
      dest_result_t ev;
      if (batch.size() < 2) begin
        ev.kind      = kind;
        ev.data_byte = data_byte;
        ev.last      = 1'b0;
        batch.push_back(ev);
      end
    endfunction

    // Walk one accepted octet MSB first and queue the events it causes
    function void note_octet(logic [7:0] raw);
      int i;
      batch.delete();
      for (i = 7; i >= 0; i--) begin
        if (raw[i]) begin
          if (run_len < RUN_MAX) run_len++;
          push_bit(1'b1);
        end else begin
          if (run_len < RUN_STUFF) begin
            push_bit(1'b0);
          end else if (run_len == RUN_FLAG) begin
            // closing zero of a possible flag; clear whether or not it matches
            shreg = {shreg[6:0], 1'b0};
            if (shreg == FLAG_PATTERN) add_event(KIND_FLAG, 8'h00);
            shreg = '0;
            nbits = '0;
          end else if (run_len >= RUN_MAX) begin
            add_event(KIND_ABORT, 8'h00);
            shreg = '0;
            nbits = '0;
          end
          // five ones: stuffed zero dropped; seven ones: only the run clears
          run_len = '0;
        end
        if (nbits == OCTET_BITS && run_len < RUN_MAX) begin
          add_event(KIND_DATA, shreg);
          shreg = '0;
          nbits = '0;
        end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k]) expected_results.push_back(batch[k]);
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data_byte, logic last);
      dest_result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d data_byte 0x%02h last %0d",
               kind, data_byte, last);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (kind !== want.kind) begin
        $error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
        errors++;
      end
      if (data_byte !== want.data_byte) begin
        $error("data_byte mismatch: expected 0x%02h, actual 0x%02h",
               want.data_byte, data_byte);
        errors++;
      end
      if (last !== want.last) begin
        $error("last mismatch: expected %0d, actual %0d", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_raw_bits = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_data_byte;
  logic       out_last;

  destuff_scoreboard sb = new();

  logic [7:0] octets[$];
  bit         line_bits[$];
  int         tx_run;
  int         directed_count;
  int         cycle_count;
  bit         in_calm;
  bit         out_calm;

  hdlc_bit_destuffer_rx_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_raw_bits   (in_raw_bits),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_last      (out_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_kind, out_data_byte, out_last);
  end

  // Per-transaction wait, with occasional stretches of none
  function automatic int pick_wait(ref bit calm);
    if ($urandom_range(0, 39) == 0) calm = ~calm;
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Line transmitter model used to build well-formed streams
  function automatic void put_bit(bit b);
    line_bits.push_back(b);
    tx_run = b ? tx_run + 1 : 0;
  endfunction

  function automatic void put_flag();
    int i;
    put_bit(1'b0);
    for (i = 0; i < 6; i++) put_bit(1'b1);
    put_bit(1'b0);
  endfunction

  function automatic void put_data_octet(logic [7:0] d);
    int i;
    for (i = 7; i >= 0; i--) begin
      put_bit(d[i]);
      if (tx_run == 5) put_bit(1'b0);
    end
  endfunction

  // Seven ones is a non-abort run; eight or more is an abort
  function automatic void put_abort();
    int n;
    n = $urandom_range(7, 14);
    repeat (n) put_bit(1'b1);
    put_bit(1'b0);
  endfunction

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 11))
      0:       return 8'hFF;
      1:       return 8'h7E;
      2:       return 8'h00;
      3:       return 8'hFC;
      4:       return 8'h3F;
      5:       return 8'hF8;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void pack_octets();
    logic [7:0] o;
    int i;
    while (line_bits.size() >= 8) begin
      for (i = 7; i >= 0; i--) o[i] = line_bits.pop_front();
      octets.push_back(o);
    end
  endfunction

  // Mostly framed traffic with random payload; some aborts and raw noise
  function automatic void build_random_stream();
    int choice;
    int n;
    while (octets.size() < directed_count + RANDOM_OCTETS) begin
      choice = $urandom_range(0, 19);
      if (choice < 14) begin
        n = $urandom_range(1, 2);
        repeat (n) put_flag();
        n = $urandom_range(1, 10);
        repeat (n) put_data_octet(pick_data());
        if ($urandom_range(0, 7) == 0) put_abort();
        put_flag();
      end else if (choice < 17) begin
        put_abort();
      end else begin
        n = $urandom_range(1, 24);
        repeat (n) put_bit(1'($urandom_range(0, 1)));
      end
      pack_octets();
    end
    while (line_bits.size() % 8 != 0) put_bit(1'b0);
    pack_octets();
  endfunction

  // Hold the sender off until every expected event has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_octets();
    int gap;
    int i;
    for (i = 0; i < octets.size(); i++) begin
      gap = pick_wait(in_calm);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid    <= 1'b1;
      in_raw_bits <= octets[i];
      do @(posedge clk); while (!in_ready);
      sb.note_octet(octets[i]);
      if (i == directed_count - 1 || $urandom_range(0, 149) == 0) wait_drained();
    end
    in_valid <= 1'b0;
  endtask

  // Result-side back-pressure
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = pick_wait(out_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    cycle_count = 0;
    tx_run      = 0;
    // Directed: extremes, flags, stuffed zero, six ones without a flag,
    // seven ones then zero, long run into abort with count saturation
    octets = '{8'h00, 8'h7E, 8'h7E, 8'hFE, 8'h00, 8'h7E, 8'hF8, 8'h00,
               8'hFC, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h7E, 8'h55,
               8'hAA, 8'h01, 8'h80, 8'h3F, 8'h7E, 8'h7E};
    directed_count = octets.size();
    build_random_stream();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_octets();

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
